// File: hw/rtl/bst_pkg.sv
// Shared types, constants and character helpers for the byte stream tokenizer.
package bst_pkg;

    localparam int MAX_LEXEME = 1023;

    localparam logic [4:0] K_KW_INT    = 5'd0;
    localparam logic [4:0] K_KW_CHAR   = 5'd1;
    localparam logic [4:0] K_KW_IF     = 5'd2;
    localparam logic [4:0] K_KW_PRINT  = 5'd3;
    localparam logic [4:0] K_KW_RETURN = 5'd4;
    localparam logic [4:0] K_IDENT     = 5'd5;
    localparam logic [4:0] K_NUM       = 5'd6;
    localparam logic [4:0] K_STR       = 5'd7;
    localparam logic [4:0] K_CHL       = 5'd8;
    localparam logic [4:0] K_EQEQ      = 5'd9;
    localparam logic [4:0] K_ASSIGN    = 5'd10;
    localparam logic [4:0] K_NE        = 5'd11;
    localparam logic [4:0] K_PLUS      = 5'd12;
    localparam logic [4:0] K_MINUS     = 5'd13;
    localparam logic [4:0] K_STAR      = 5'd14;
    localparam logic [4:0] K_LPAREN    = 5'd15;
    localparam logic [4:0] K_RPAREN    = 5'd16;
    localparam logic [4:0] K_GT        = 5'd17;
    localparam logic [4:0] K_LT        = 5'd18;
    localparam logic [4:0] K_LBRACE    = 5'd19;
    localparam logic [4:0] K_RBRACE    = 5'd20;
    localparam logic [4:0] K_LBRACK    = 5'd21;
    localparam logic [4:0] K_RBRACK    = 5'd22;
    localparam logic [4:0] K_COMMA     = 5'd23;
    localparam logic [4:0] K_DIV       = 5'd24;
    localparam logic [4:0] K_SEMI      = 5'd25;
    localparam logic [4:0] K_UNK       = 5'd26;
    localparam logic [4:0] K_END       = 5'd27;
    localparam logic [4:0] K_ERR_STR   = 5'd28;
    localparam logic [4:0] K_ERR_LNG   = 5'd29;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM, M_EQ, M_BANG, M_SLASH, M_COMMENT, M_STR,
        M_CQ1, M_CQ2, M_HALT, M_DONE
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [23:0] start;
        logic [9:0]  len;
        logic        last;
    } t_tok;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h3E:   k = K_GT;
            8'h3C:   k = K_LT;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h2C:   k = K_COMMA;
            default: k = K_UNK;
        endcase
        return k;
    endfunction

    // keyword match on the captured first six bytes, right-justified
    function automatic logic [4:0] word_kind(input logic [9:0] len, input logic [47:0] w);
        logic [4:0] k;
        k = K_IDENT;
        if (len == 10'd3 && w == 48'h696E74)       k = K_KW_INT;
        if (len == 10'd4 && w == 48'h63686172)     k = K_KW_CHAR;
        if (len == 10'd2 && w == 48'h6966)         k = K_KW_IF;
        if (len == 10'd5 && w == 48'h7072696E74)   k = K_KW_PRINT;
        if (len == 10'd6 && w == 48'h72657475726E) k = K_KW_RETURN;
        return k;
    endfunction

endpackage

// File: hw/rtl/byte_stream_tokenizer.sv
// Streaming lexer: one source byte per word in, up to two token records per byte out.
// A token record is registered into the output queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while each byte yields at most one record and the output
// is not stalled; records wait in a three-slot output queue.
// Input stall is high while two or more records are queued.
// Reset (synchronous, active low) returns to idle with all counts zero and the queue empty.
module byte_stream_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic [23:0] o_text_start,
    output logic [9:0]  o_text_length,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    bst_pkg::t_mode r_mode, n_mode;
    logic [47:0] r_word, n_word;
    logic [9:0]  r_len, n_len;
    logic [15:0] r_line, n_line;
    logic [15:0] r_col, n_col;
    logic [23:0] r_bidx, n_bidx;
    logic [23:0] r_tstart, n_tstart;
    logic [15:0] r_tcol, n_tcol;

    bst_pkg::t_tok r_q [3];
    bst_pkg::t_tok n_q [3];
    logic [1:0] r_cnt, n_cnt;

    bst_pkg::t_tok rec_a, rec_b, rec0, rec1;
    logic        a_v, b_v, go_b;
    logic [15:0] col_a, line_out;
    logic [7:0]  c;
    logic        acc, pop;
    logic [1:0]  base, nres;
    logic        long_err;

    assign acc      = i_valid && !o_stall;
    assign pop      = o_valid && !i_stall;
    assign c        = i_in_byte;
    assign line_out = bst_pkg::sat_inc16(r_line);
    assign long_err = r_len >= 10'(bst_pkg::MAX_LEXEME);

    always_comb begin : lex_step
        n_mode = r_mode; n_word = r_word; n_len = r_len; n_line = r_line;
        n_col = r_col; n_bidx = r_bidx; n_tstart = r_tstart; n_tcol = r_tcol;
        a_v = 1'b0; b_v = 1'b0; go_b = 1'b0;
        col_a = r_col;
        rec_a = '{kind: bst_pkg::K_UNK, line: line_out, column: r_tcol,
                  start: r_tstart, len: 10'd0, last: 1'b0};
        rec_b = '{kind: bst_pkg::K_END, line: line_out, column: r_col,
                  start: r_bidx, len: 10'd0, last: 1'b0};

        if (r_mode != bst_pkg::M_HALT && r_mode != bst_pkg::M_DONE) begin
            if (i_end_of_input) begin
                n_mode = bst_pkg::M_DONE;
                b_v = 1'b1;
                case (r_mode)
                    bst_pkg::M_IDENT, bst_pkg::M_NUM: begin
                        a_v = 1'b1;
                        if (long_err) begin
                            rec_a.kind = bst_pkg::K_ERR_LNG;
                            n_mode = bst_pkg::M_HALT;
                            b_v = 1'b0;
                        end else begin
                            rec_a.kind = (r_mode == bst_pkg::M_NUM) ? bst_pkg::K_NUM
                                         : bst_pkg::word_kind(r_len, r_word);
                            rec_a.len = r_len;
                            col_a = bst_pkg::sat_inc16(r_col);
                        end
                    end
                    bst_pkg::M_EQ: begin
                        a_v = 1'b1; rec_a.kind = bst_pkg::K_ASSIGN; rec_a.len = 10'd1;
                        col_a = bst_pkg::sat_inc16(r_col);
                    end
                    bst_pkg::M_BANG: begin
                        a_v = 1'b1; rec_a.kind = bst_pkg::K_UNK; rec_a.len = 10'd1;
                        col_a = bst_pkg::sat_inc16(r_col);
                    end
                    bst_pkg::M_SLASH: begin
                        a_v = 1'b1; rec_a.kind = bst_pkg::K_DIV; rec_a.len = 10'd1;
                        col_a = bst_pkg::sat_inc16(r_col);
                    end
                    bst_pkg::M_COMMENT: col_a = bst_pkg::sat_inc16(r_col);
                    bst_pkg::M_STR: begin
                        a_v = 1'b1; rec_a.kind = bst_pkg::K_ERR_STR;
                        n_mode = bst_pkg::M_HALT;
                        b_v = 1'b0;
                    end
                    bst_pkg::M_CQ1: begin
                        a_v = 1'b1; rec_a.kind = bst_pkg::K_CHL;
                        col_a = bst_pkg::sat_inc16(r_col);
                    end
                    bst_pkg::M_CQ2: begin
                        a_v = 1'b1; rec_a.kind = bst_pkg::K_CHL; rec_a.len = 10'd1;
                        col_a = bst_pkg::sat_inc16(r_col);
                    end
                    default: ;
                endcase
                n_col = col_a;
                if (b_v) begin
                    n_tcol = col_a;
                    rec_b.column = col_a;
                end
            end else begin
                n_bidx = r_bidx + 24'd1;
                case (r_mode)
                    bst_pkg::M_IDENT, bst_pkg::M_NUM: begin
                        if (bst_pkg::is_digit(c) ||
                            (r_mode == bst_pkg::M_IDENT && bst_pkg::is_alpha(c))) begin
                            if (r_len < 10'd6) n_word = {r_word[39:0], c};
                            if (!long_err) n_len = r_len + 10'd1;
                        end else begin
                            a_v = 1'b1;
                            if (long_err) begin
                                rec_a.kind = bst_pkg::K_ERR_LNG;
                                n_mode = bst_pkg::M_HALT;
                            end else begin
                                rec_a.kind = (r_mode == bst_pkg::M_NUM) ? bst_pkg::K_NUM
                                             : bst_pkg::word_kind(r_len, r_word);
                                rec_a.len = r_len;
                                col_a = bst_pkg::sat_inc16(r_col);
                                go_b = 1'b1;
                            end
                        end
                    end
                    bst_pkg::M_EQ, bst_pkg::M_BANG: begin
                        a_v = 1'b1;
                        col_a = bst_pkg::sat_inc16(r_col);
                        if (c == 8'h3D) begin
                            rec_a.kind = (r_mode == bst_pkg::M_EQ) ? bst_pkg::K_EQEQ
                                                                    : bst_pkg::K_NE;
                            rec_a.len = 10'd2;
                            n_mode = bst_pkg::M_IDLE;
                        end else begin
                            rec_a.kind = (r_mode == bst_pkg::M_EQ) ? bst_pkg::K_ASSIGN
                                                                    : bst_pkg::K_UNK;
                            rec_a.len = 10'd1;
                            go_b = 1'b1;
                        end
                    end
                    bst_pkg::M_SLASH: begin
                        if (c == 8'h2F) begin
                            n_mode = bst_pkg::M_COMMENT;
                        end else begin
                            a_v = 1'b1; rec_a.kind = bst_pkg::K_DIV; rec_a.len = 10'd1;
                            col_a = bst_pkg::sat_inc16(r_col);
                            go_b = 1'b1;
                        end
                    end
                    bst_pkg::M_COMMENT: begin
                        if (c == 8'd10) begin
                            n_line = bst_pkg::sat_inc16(r_line);
                            col_a = 16'd0;
                            n_mode = bst_pkg::M_IDLE;
                        end else begin
                            col_a = bst_pkg::sat_inc16(r_col);
                        end
                    end
                    bst_pkg::M_STR: begin
                        if (c != 8'h22) begin
                            if (!long_err) n_len = r_len + 10'd1;
                        end else if (long_err) begin
                            a_v = 1'b1; rec_a.kind = bst_pkg::K_ERR_LNG;
                            n_mode = bst_pkg::M_HALT;
                        end else begin
                            a_v = 1'b1; rec_a.kind = bst_pkg::K_STR; rec_a.len = r_len;
                            col_a = bst_pkg::sat_inc16(r_col);
                            n_mode = bst_pkg::M_IDLE;
                        end
                    end
                    bst_pkg::M_CQ1: begin
                        if (c == 8'h27) begin
                            a_v = 1'b1; rec_a.kind = bst_pkg::K_CHL;
                            col_a = bst_pkg::sat_inc16(r_col);
                            n_mode = bst_pkg::M_IDLE;
                        end else begin
                            n_len = 10'd1;
                            n_mode = bst_pkg::M_CQ2;
                        end
                    end
                    bst_pkg::M_CQ2: begin
                        a_v = 1'b1; rec_a.kind = bst_pkg::K_CHL; rec_a.len = 10'd1;
                        col_a = bst_pkg::sat_inc16(r_col);
                        n_mode = bst_pkg::M_IDLE;
                        go_b = (c != 8'h27);
                    end
                    default: go_b = 1'b1;
                endcase
                n_col = col_a;

                // fresh lexing of this byte from idle
                if (go_b) begin
                    n_mode = bst_pkg::M_IDLE;
                    rec_b = '{kind: bst_pkg::single_kind(c), line: line_out, column: col_a,
                              start: r_bidx, len: 10'd1, last: 1'b0};
                    if (bst_pkg::is_space(c)) begin
                        if (c == 8'd10) begin
                            n_line = bst_pkg::sat_inc16(r_line);
                            n_col = 16'd0;
                        end
                    end else begin
                        n_tcol = col_a;
                        n_tstart = r_bidx;
                        n_len = 10'd0;
                        n_word = 48'd0;
                        if (bst_pkg::is_alpha(c) || bst_pkg::is_digit(c)) begin
                            n_mode = bst_pkg::is_alpha(c) ? bst_pkg::M_IDENT : bst_pkg::M_NUM;
                            n_word = {40'd0, c};
                            n_len = 10'd1;
                        end else begin
                            case (c)
                                8'h3D: n_mode = bst_pkg::M_EQ;
                                8'h21: n_mode = bst_pkg::M_BANG;
                                8'h2F: n_mode = bst_pkg::M_SLASH;
                                8'h22: begin
                                    n_mode = bst_pkg::M_STR;
                                    n_tstart = r_bidx + 24'd1;
                                end
                                8'h27: begin
                                    n_mode = bst_pkg::M_CQ1;
                                    n_tstart = r_bidx + 24'd1;
                                end
                                8'h3B: begin
                                    b_v = 1'b1;
                                    rec_b.kind = bst_pkg::K_SEMI;
                                    n_col = 16'd0;
                                end
                                default: begin
                                    b_v = 1'b1;
                                    n_col = bst_pkg::sat_inc16(col_a);
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    // output queue: head in slot 0, new records appended after the survivors
    always_comb begin : queue_next
        n_q[0] = r_q[1];
        n_q[1] = r_q[2];
        n_q[2] = r_q[2];
        base = r_cnt - {1'b0, pop};
        nres = 2'd0;
        rec0 = a_v ? rec_a : rec_b;
        rec1 = rec_b;
        if (acc) nres = {1'b0, a_v} + {1'b0, b_v};
        rec0.last = (nres == 2'd1);
        rec1.last = 1'b1;
        if (!pop) begin
            n_q[0] = r_q[0];
            n_q[1] = r_q[1];
        end
        for (int i = 0; i < 3; i++) begin
            if (nres != 2'd0 && 2'(i) == base) n_q[i] = rec0;
            if (nres == 2'd2 && 2'(i) == base + 2'd1) n_q[i] = rec1;
        end
        n_cnt = base + nres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= bst_pkg::M_IDLE;
            r_word   <= '0;
            r_len    <= '0;
            r_line   <= '0;
            r_col    <= '0;
            r_bidx   <= '0;
            r_tstart <= '0;
            r_tcol   <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (acc) begin
                r_mode   <= n_mode;
                r_word   <= n_word;
                r_len    <= n_len;
                r_line   <= n_line;
                r_col    <= n_col;
                r_bidx   <= n_bidx;
                r_tstart <= n_tstart;
                r_tcol   <= n_tcol;
            end
            if (i_cfg_we) r_line <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_stall        = r_cnt > 2'd1;
    assign o_valid        = r_cnt != 2'd0;
    assign o_token_kind   = r_q[0].kind;
    assign o_token_line   = r_q[0].line;
    assign o_token_column = r_q[0].column;
    assign o_text_start   = r_q[0].start;
    assign o_text_length  = r_q[0].len;
    assign o_last_of_run  = r_q[0].last;

`ifndef SYNTHESIS
    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == bst_pkg::M_DONE |=> r_mode == bst_pkg::M_DONE)
        else $error("left done state without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_mode == bst_pkg::M_HALT) |=> r_cnt <= $past(r_cnt))
        else $error("records produced while halted");

    a_index_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_bidx))
        else $error("byte index moved without an accepted word");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3 || !pop || !acc)
        else $error("word accepted with a full queue");
`endif

endmodule
